### rtl/core/nrmc_pkg.sv
`timescale 1ns / 1ps

package nrmc_pkg;

    localparam logic [3:0] FRAC_DIGITS = 4'd5;

    localparam logic [3:0] TIME_INT_DIGITS = 4'd6;
    localparam logic [3:0] LAT_INT_DIGITS  = 4'd4;
    localparam logic [3:0] LON_INT_DIGITS  = 4'd5;
    localparam logic [3:0] NO_FRAC         = 4'd0;
    localparam logic [3:0] FRAC_START      = 4'd8;
    localparam logic [3:0] DATE_DIGITS     = 4'd6;
    localparam logic [3:0] MAX_DIGITS      = 4'd10;

    localparam logic [4:0] ZONE_RESET = 5'd8;
    localparam logic [3:0] COMMA_MAX  = 4'd15;
    localparam logic [3:0] COMMA_FULL = 4'd11;
    localparam logic [2:0] PREFIX_DONE = 3'd5;
    localparam logic [2:0] PREFIX_TALKER = 3'd2;
    localparam logic [2:0] PREFIX_TYPE   = 3'd4;
    localparam logic [1:0] MODE_DELAY    = 2'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // field number = commas seen so far
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_MODE   = 4'd10;

    localparam logic [7:0] HOURS_DAY = 8'd24;

    typedef struct packed {
        logic [39:0] digits;
        logic [3:0]  count;
    } num_upd_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [39:0] put_nibble(input logic [39:0] r, input logic [3:0] pos,
                                               input logic [3:0] total, input logic [3:0] d);
        logic [3:0]  idx;
        logic [39:0] res;
        idx = total - 4'd1 - pos;
        res = r;
        if ((pos < total) && (total <= MAX_DIGITS))
        begin
            res = r | ({36'd0, d} << {idx, 2'b00});
        end
        return res;
    endfunction

    function automatic num_upd_t take_number(input logic [39:0] r, input logic [3:0] dc,
                                             input logic [7:0] b, input logic [3:0] int_digits,
                                             input logic [3:0] frac);
        num_upd_t   u;
        logic [3:0] total;
        logic [3:0] fpos;
        u.digits = r;
        u.count  = dc;
        total    = int_digits + frac;
        fpos     = dc - FRAC_START;
        if (b == CH_DOT)
        begin
            if (dc < FRAC_START)
            begin
                u.count = FRAC_START;
            end
        end
        else if (is_digit(b))
        begin
            if (dc < FRAC_START)
            begin
                if (dc < int_digits)
                begin
                    u.digits = put_nibble(r, dc, total, b[3:0]);
                    u.count  = dc + 4'd1;
                end
            end
            else if (fpos < frac)
            begin
                u.digits = put_nibble(r, int_digits + fpos, total, b[3:0]);
                u.count  = dc + 4'd1;
            end
        end
        return u;
    endfunction

    // x mod 24 = 8 * ((x >> 3) mod 3) + (x mod 8); the mod 3 folds base-4 digits
    function automatic logic [4:0] mod_24(input logic [7:0] x);
        logic [2:0] s;
        logic [1:0] m3;
        s = {1'b0, x[4:3]} + {1'b0, x[6:5]} + {2'b00, x[7]};
        if (s >= 3'd6)
        begin
            m3 = 2'(s - 3'd6);
        end
        else if (s >= 3'd3)
        begin
            m3 = 2'(s - 3'd3);
        end
        else
        begin
            m3 = s[1:0];
        end
        return {m3, x[2:0]};
    endfunction

    function automatic logic [7:0] hour_to_bcd(input logic [4:0] h);
        logic [7:0] res;
        if (h >= 5'd20)
        begin
            res = {4'd2, 4'(h - 5'd20)};
        end
        else if (h >= 5'd10)
        begin
            res = {4'd1, 4'(h - 5'd10)};
        end
        else
        begin
            res = {4'd0, h[3:0]};
        end
        return res;
    endfunction

endpackage

### rtl/core/nrmc_ifs.sv
`timescale 1ns / 1ps

interface nrmc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] zone_offset_hours;

    modport source (output valid, output zone_offset_hours, input ready);
    modport sink   (input valid, input zone_offset_hours, output ready);
endinterface

interface nrmc_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic        fix_active;
    logic [23:0] utc_time_bcd;
    logic [23:0] local_time_bcd;
    logic [23:0] date_bcd;
    logic [35:0] latitude_bcd;
    logic        north;
    logic [39:0] longitude_bcd;
    logic        east;
    logic [7:0]  mode_char;

    modport source (output valid, output valid_res, output fix_active, output utc_time_bcd,
                    output local_time_bcd, output date_bcd, output latitude_bcd, output north,
                    output longitude_bcd, output east, output mode_char, input ready);
    modport sink   (input valid, input valid_res, input fix_active, input utc_time_bcd,
                    input local_time_bcd, input date_bcd, input latitude_bcd, input north,
                    input longitude_bcd, input east, input mode_char, output ready);
endinterface

### rtl/core/nmea_rmc_sentence_parser.sv
`timescale 1ns / 1ps

// NMEA 0183 RMC parser, one received byte per request on rx. A '$' opens a sentence;
// talker/type bytes are checked for an RMC sentence, then time, status, latitude, N/S,
// longitude, E/W, date (reordered to yymmdd) and the mode byte are packed as BCD.
// A CR or LF closing an RMC sentence emits one request on res; local time is the UTC
// hour plus zone_offset_hours, modulo 24 (cfg, write only while idle; resets to 8).
// Throughput is one byte per clock unless the input stalls as below. Each byte is parsed
// in the cycle after it is accepted into the input register, and a result is registered
// on res when the CR or LF that closes its sentence advances out of the input register.
// The result register stalls the input only when a second RMC sentence end arrives while
// the previous result has not been taken.
module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nrmc_rx_if.sink      rx,
    nrmc_cfg_if.sink     cfg,
    nrmc_res_if.source   res
);

    logic [4:0]  zone_reg;

    logic        st_valid_reg;
    logic [7:0]  st_byte_reg;

    logic        in_sentence_reg, in_sentence_next;
    logic [2:0]  prefix_reg, prefix_next;
    logic        is_rmc_reg, is_rmc_next;
    logic [3:0]  comma_reg, comma_next;
    logic [3:0]  digit_reg, digit_next;
    logic [1:0]  after_date_reg, after_date_next;
    logic [23:0] time_reg, time_next;
    logic [23:0] date_reg, date_next;
    logic [35:0] lat_reg, lat_next;
    logic [39:0] lon_reg, lon_next;
    logic [1:0]  hemi_reg, hemi_next;
    logic        fix_reg, fix_next;
    logic [7:0]  mode_reg, mode_next;

    logic        emit;
    logic        advance;
    logic        out_valid_reg;

    logic [7:0]  b;
    num_upd_t    num;
    logic [3:0]  date_pos;
    logic [39:0] date_wide;
    logic [7:0]  utc_hours;
    logic [4:0]  loc_hours;

    assign b = st_byte_reg;

    // a byte that ends no sentence may pass even while a result waits
    assign advance  = st_valid_reg && (!out_valid_reg || res.ready || !emit);
    assign rx.ready = !st_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        prefix_next      = prefix_reg;
        is_rmc_next      = is_rmc_reg;
        comma_next       = comma_reg;
        digit_next       = digit_reg;
        after_date_next  = after_date_reg;
        time_next        = time_reg;
        date_next        = date_reg;
        lat_next         = lat_reg;
        lon_next         = lon_reg;
        hemi_next        = hemi_reg;
        fix_next         = fix_reg;
        mode_next        = mode_reg;
        emit             = 1'b0;
        num              = '0;
        date_pos         = '0;
        date_wide        = '0;

        if (b == CH_DOLLAR)
        begin
            in_sentence_next = 1'b1;
            prefix_next      = 3'd1;
            is_rmc_next      = 1'b1;
            comma_next       = '0;
            digit_next       = '0;
            after_date_next  = '0;
            time_next        = '0;
            date_next        = '0;
            lat_next         = '0;
            lon_next         = '0;
            hemi_next        = '0;
            mode_next        = '0;
        end
        else if (!in_sentence_reg)
        begin
            // outside a sentence: nothing to do
        end
        else if ((b == CH_CR) || (b == CH_LF))
        begin
            in_sentence_next = 1'b0;
            emit = is_rmc_reg && (prefix_reg == PREFIX_DONE);
        end
        else if (prefix_reg < PREFIX_DONE)
        begin
            if ((prefix_reg == PREFIX_TALKER) && (b != CH_N))
            begin
                is_rmc_next = 1'b0;
            end
            if ((prefix_reg == PREFIX_TYPE) && (b != CH_M))
            begin
                is_rmc_next = 1'b0;
            end
            prefix_next = prefix_reg + 3'd1;
        end
        else if (is_rmc_reg)
        begin
            if (after_date_reg != 2'd0)
            begin
                if (after_date_reg == 2'd1)
                begin
                    mode_next = b;
                end
                after_date_next = after_date_reg - 2'd1;
            end

            if (b == CH_COMMA)
            begin
                if (comma_reg < COMMA_MAX)
                begin
                    comma_next = comma_reg + 4'd1;
                end
                digit_next = '0;
                case (comma_next)
                    FLD_TIME:   time_next = '0;
                    FLD_LAT:    lat_next = '0;
                    FLD_NS:     hemi_next[0] = 1'b0;
                    FLD_LON:    lon_next = '0;
                    FLD_EW:     hemi_next[1] = 1'b0;
                    FLD_DATE:   date_next = '0;
                    FLD_MODE:   after_date_next = MODE_DELAY;
                    default:    ;
                endcase
            end
            else
            begin
                case (comma_reg)
                    FLD_TIME:
                    begin
                        num = take_number({16'd0, time_reg}, digit_reg, b,
                                          TIME_INT_DIGITS, NO_FRAC);
                        time_next  = num.digits[23:0];
                        digit_next = num.count;
                    end
                    FLD_STATUS:
                    begin
                        if (digit_reg == 4'd0)
                        begin
                            if (b == CH_A)
                            begin
                                fix_next = 1'b1;
                            end
                            else if (b == CH_V)
                            begin
                                fix_next = 1'b0;
                            end
                            digit_next = 4'd1;
                        end
                    end
                    FLD_LAT:
                    begin
                        num = take_number({4'd0, lat_reg}, digit_reg, b,
                                          LAT_INT_DIGITS, FRAC_DIGITS);
                        lat_next   = num.digits[35:0];
                        digit_next = num.count;
                    end
                    FLD_NS:
                    begin
                        if (digit_reg == 4'd0)
                        begin
                            if (b == CH_N)
                            begin
                                hemi_next[0] = 1'b1;
                            end
                            digit_next = 4'd1;
                        end
                    end
                    FLD_LON:
                    begin
                        num = take_number(lon_reg, digit_reg, b,
                                          LON_INT_DIGITS, FRAC_DIGITS);
                        lon_next   = num.digits;
                        digit_next = num.count;
                    end
                    FLD_EW:
                    begin
                        if (digit_reg == 4'd0)
                        begin
                            if (b == CH_E)
                            begin
                                hemi_next[1] = 1'b1;
                            end
                            digit_next = 4'd1;
                        end
                    end
                    FLD_DATE:
                    begin
                        if (is_digit(b) && (digit_reg < DATE_DIGITS))
                        begin
                            // ddmmyy in, yymmdd out
                            date_pos   = {1'b0, 2'd2 - digit_reg[2:1], digit_reg[0]};
                            date_wide  = put_nibble({16'd0, date_reg}, date_pos,
                                                    DATE_DIGITS, b[3:0]);
                            date_next  = date_wide[23:0];
                            digit_next = digit_reg + 4'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign utc_hours = {1'b0, time_reg[23:20], 3'b000} + {3'b000, time_reg[23:20], 1'b0}
                     + {4'd0, time_reg[19:16]};
    assign loc_hours = mod_24(utc_hours + {3'd0, zone_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg        <= ZONE_RESET;
            st_valid_reg    <= 1'b0;
            in_sentence_reg <= 1'b0;
            prefix_reg      <= '0;
            is_rmc_reg      <= 1'b0;
            comma_reg       <= '0;
            digit_reg       <= '0;
            after_date_reg  <= '0;
            time_reg        <= '0;
            date_reg        <= '0;
            lat_reg         <= '0;
            lon_reg         <= '0;
            hemi_reg        <= '0;
            fix_reg         <= 1'b0;
            mode_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                zone_reg <= cfg.zone_offset_hours;
            end

            if (rx.valid && rx.ready)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                st_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                in_sentence_reg <= in_sentence_next;
                prefix_reg      <= prefix_next;
                is_rmc_reg      <= is_rmc_next;
                comma_reg       <= comma_next;
                digit_reg       <= digit_next;
                after_date_reg  <= after_date_next;
                time_reg        <= time_next;
                date_reg        <= date_next;
                lat_reg         <= lat_next;
                lon_reg         <= lon_next;
                hemi_reg        <= hemi_next;
                fix_reg         <= fix_next;
                mode_reg        <= mode_next;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            st_byte_reg <= rx.rx_byte;
        end

        if (advance && emit)
        begin
            res.valid_res      <= (comma_reg >= COMMA_FULL);
            res.fix_active     <= fix_reg;
            res.utc_time_bcd   <= time_reg;
            res.local_time_bcd <= {hour_to_bcd(loc_hours), time_reg[15:0]};
            res.date_bcd       <= date_reg;
            res.latitude_bcd   <= lat_reg;
            res.north          <= hemi_reg[0];
            res.longitude_bcd  <= lon_reg;
            res.east           <= hemi_reg[1];
            res.mode_char      <= mode_reg;
        end
    end

endmodule

### verif/nmea_rmc_sentence_parser_test.sv
`timescale 1ns / 1ps

module nmea_rmc_sentence_parser_test;
    import nrmc_pkg::*;

    typedef struct {
        logic        valid_res;
        logic        fix_active;
        logic [23:0] utc_time;
        logic [23:0] loc_time;
        logic [23:0] date;
        logic [35:0] lat;
        logic        north;
        logic [39:0] lon;
        logic        east;
        logic [7:0]  mode;
    } rmc_fix_t;

    logic clk;
    logic rst_n;

    nrmc_rx_if  rx_bus();
    nrmc_cfg_if cfg_bus();
    nrmc_res_if res_bus();

    nmea_rmc_sentence_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .cfg   (cfg_bus),
        .res   (res_bus)
    );

    // parser shadow state
    logic        sent_open;
    int          prefix_idx;
    logic        rmc_ok;
    logic [3:0]  field_no;
    int          digit_pos;
    int          mode_wait;
    logic [23:0] m_time;
    logic [23:0] m_date;
    logic [35:0] m_lat;
    logic [39:0] m_lon;
    logic        m_north;
    logic        m_east;
    logic        m_fix;
    logic [7:0]  m_mode;
    logic [4:0]  m_zone;

    logic [7:0] bytes_to_send[$];
    rmc_fix_t   fixes_due[$];

    int  send_gap_pct;
    int  take_stall_pct;
    bit  rx_offered;
    int  fill_count;
    int  mismatches;
    int  fixes_checked;
    int  bytes_taken;
    int  zone_writes;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("nmea_rmc_sentence_parser_test NOT OK");
        $finish;
    end

    function automatic logic [39:0] set_digit(input logic [39:0] acc, input int slot,
                                              input int ndig, input logic [7:0] ch);
        logic [39:0] r;
        r = acc;
        if (slot < ndig)
        begin
            r[4 * (ndig - 1 - slot) +: 4] = r[4 * (ndig - 1 - slot) +: 4] | ch[3:0];
        end
        return r;
    endfunction

    // integer part fills slots 0..int_len-1, fraction continues after; '.' jumps to fraction
    task automatic consume_number(inout logic [39:0] acc, input logic [7:0] ch,
                                  input int int_len, input int frac_len);
        int slot;
        int limit;
        if (ch == CH_DOT)
        begin
            if (digit_pos < FRAC_START)
            begin
                digit_pos = FRAC_START;
            end
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            slot  = (digit_pos < FRAC_START) ? digit_pos : int_len + digit_pos - FRAC_START;
            limit = (digit_pos < FRAC_START) ? int_len : int_len + frac_len;
            if (slot < limit)
            begin
                acc = set_digit(acc, slot, int_len + frac_len, ch);
                digit_pos++;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] ch);
        logic [39:0] acc;
        logic [3:0]  tens;
        logic [3:0]  units;
        int          hour;
        int          lh;
        int          slot;
        rmc_fix_t    fix;
        if (ch == CH_DOLLAR)
        begin
            sent_open  = 1'b1;
            prefix_idx = 1;
            rmc_ok     = 1'b1;
            field_no   = '0;
            digit_pos  = 0;
            mode_wait  = 0;
            m_time     = '0;
            m_date     = '0;
            m_lat      = '0;
            m_lon      = '0;
            m_north    = 1'b0;
            m_east     = 1'b0;
            m_mode     = '0;
            return;
        end
        if (!sent_open)
        begin
            return;
        end
        if (ch == CH_CR || ch == CH_LF)
        begin
            sent_open = 1'b0;
            if (rmc_ok && prefix_idx == PREFIX_DONE)
            begin
                hour  = m_time[23:20] * 10 + m_time[19:16];
                lh    = (hour + m_zone) % HOURS_DAY;
                tens  = 4'(lh / 10);
                units = 4'(lh % 10);
                fix.valid_res  = (field_no >= COMMA_FULL);
                fix.fix_active = m_fix;
                fix.utc_time   = m_time;
                fix.loc_time   = {tens, units, m_time[15:0]};
                fix.date       = m_date;
                fix.lat        = m_lat;
                fix.north      = m_north;
                fix.lon        = m_lon;
                fix.east       = m_east;
                fix.mode       = m_mode;
                fixes_due.push_back(fix);
            end
            return;
        end
        if (prefix_idx < PREFIX_DONE)
        begin
            if (prefix_idx == PREFIX_TALKER && ch != CH_N)
            begin
                rmc_ok = 1'b0;
            end
            if (prefix_idx == PREFIX_TYPE && ch != CH_M)
            begin
                rmc_ok = 1'b0;
            end
            prefix_idx++;
            return;
        end
        if (!rmc_ok)
        begin
            return;
        end
        // mode byte: third byte after the comma that closes the date
        if (mode_wait != 0)
        begin
            if (mode_wait == 1)
            begin
                m_mode = ch;
            end
            mode_wait--;
        end
        if (ch == CH_COMMA)
        begin
            if (field_no != COMMA_MAX)
            begin
                field_no++;
            end
            digit_pos = 0;
            case (field_no)
                FLD_TIME: m_time    = '0;
                FLD_LAT:  m_lat     = '0;
                FLD_NS:   m_north   = 1'b0;
                FLD_LON:  m_lon     = '0;
                FLD_EW:   m_east    = 1'b0;
                FLD_DATE: m_date    = '0;
                FLD_MODE: mode_wait = MODE_DELAY;
                default:  ;
            endcase
            return;
        end
        case (field_no)
            FLD_TIME:
            begin
                acc = {16'd0, m_time};
                consume_number(acc, ch, TIME_INT_DIGITS, NO_FRAC);
                m_time = acc[23:0];
            end
            FLD_STATUS:
            begin
                if (digit_pos == 0)
                begin
                    if (ch == CH_A)
                    begin
                        m_fix = 1'b1;
                    end
                    else if (ch == CH_V)
                    begin
                        m_fix = 1'b0;
                    end
                    digit_pos = 1;
                end
            end
            FLD_LAT:
            begin
                acc = {4'd0, m_lat};
                consume_number(acc, ch, LAT_INT_DIGITS, FRAC_DIGITS);
                m_lat = acc[35:0];
            end
            FLD_NS:
            begin
                if (digit_pos == 0)
                begin
                    m_north   = (ch == CH_N);
                    digit_pos = 1;
                end
            end
            FLD_LON:
            begin
                acc = m_lon;
                consume_number(acc, ch, LON_INT_DIGITS, FRAC_DIGITS);
                m_lon = acc;
            end
            FLD_EW:
            begin
                if (digit_pos == 0)
                begin
                    m_east    = (ch == CH_E);
                    digit_pos = 1;
                end
            end
            FLD_DATE:
            begin
                // ddmmyy arrives, yymmdd is stored
                if (ch >= CH_ZERO && ch <= CH_NINE && digit_pos < DATE_DIGITS)
                begin
                    slot   = 4 - 2 * (digit_pos / 2) + digit_pos % 2;
                    acc    = {16'd0, m_date};
                    acc    = set_digit(acc, slot, DATE_DIGITS, ch);
                    m_date = acc[23:0];
                    digit_pos++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        bytes_to_send.push_back(b);
        fill_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end
        while (b == CH_DOLLAR || b == CH_COMMA || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic push_digits(input int n);
        int style;
        style = $urandom_range(0, 7);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_byte(junk_byte());
            end
            if (style == 0)
            begin
                push_byte(CH_NINE);
            end
            else if (style == 1)
            begin
                push_byte(CH_ZERO);
            end
            else
            begin
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic push_number(input int typ, input int imax, input int fmax);
        push_digits($urandom_range(0, 1) ? typ : $urandom_range(0, imax));
        if ($urandom_range(0, 3) != 0)
        begin
            push_byte(CH_DOT);
            push_digits($urandom_range(0, fmax));
        end
    endtask

    task automatic push_letter(input logic [7:0] a, input logic [7:0] b);
        case ($urandom_range(0, 3))
            0:       push_byte(a);
            1:       push_byte(b);
            2:       push_byte(junk_byte());
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            push_byte(junk_byte());
        end
    endtask

    task automatic push_line_end(input bit may_omit);
        case ($urandom_range(0, 2))
            0: push_byte(CH_CR);
            1: push_byte(CH_LF);
            default:
            begin
                if (!may_omit)
                begin
                    push_byte(CH_CR);
                    push_byte(CH_LF);
                end
            end
        endcase
    endtask

    task automatic queue_rmc(input bit broken);
        string hexdig;
        int    nf;
        hexdig = "0123456789ABCDEF";
        nf     = broken ? $urandom_range(0, 11) : 12;
        if (!broken && $urandom_range(0, 9) == 0)
        begin
            nf = $urandom_range(13, 18);
        end
        push_byte(CH_DOLLAR);
        push_byte(CH_A + 8'($urandom_range(0, 25)));
        push_byte(CH_N);
        push_byte(CH_A + 8'($urandom_range(0, 25)));
        push_byte(CH_M);
        if ($urandom_range(0, 7) != 0)
        begin
            push_text("C");
        end
        for (int k = 0; k < nf; k++)
        begin
            push_byte(CH_COMMA);
            case (k)
                0:       push_number(6, 8, 3);
                1:       push_letter(CH_A, CH_V);
                2:       push_number(4, 6, 7);
                3:       push_letter(CH_N, "S");
                4:       push_number(5, 7, 7);
                5:       push_letter(CH_E, "W");
                8:       push_digits($urandom_range(0, 2) ? 6 : $urandom_range(0, 8));
                10:      push_letter(CH_E, "W");
                11:      push_letter(CH_A, "D");
                default: push_number(2, 3, 2);
            endcase
        end
        if (!broken)
        begin
            push_text("*");
            push_byte(hexdig[$urandom_range(0, 15)]);
            push_byte(hexdig[$urandom_range(0, 15)]);
        end
        push_line_end(broken);
    endtask

    task automatic queue_other();
        case ($urandom_range(0, 3))
            0:       push_text("$GPRMC");
            1:       push_text("$GNGGA");
            2:       push_text("$G");
            default: push_text("$GNR");
        endcase
        for (int k = $urandom_range(0, 12); k > 0; k--)
        begin
            push_byte(CH_COMMA);
            push_number(4, 6, 4);
        end
        push_line_end(1'b0);
    endtask

    task automatic queue_noise();
        for (int n = $urandom_range(1, 6); n > 0; n--)
        begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_random_sentence();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 72)
        begin
            queue_rmc(1'b0);
        end
        else if (sel < 82)
        begin
            queue_rmc(1'b1);
        end
        else if (sel < 91)
        begin
            queue_other();
        end
        else
        begin
            queue_noise();
        end
    endtask

    task automatic write_zone(input logic [4:0] hours);
        @(negedge clk);
        cfg_bus.valid             <= 1'b1;
        cfg_bus.zone_offset_hours <= hours;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        zone_writes++;
    endtask

    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || fixes_due.size() != 0)
        begin
            @(posedge clk);
        end
        // bytes that give no fix may still be in the pipe
        repeat (8) @(posedge clk);
    endtask

    // driver: rx requests and result back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_bus.valid  <= 1'b0;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (!rx_offered)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= bytes_to_send[0];
                    rx_offered = 1'b1;
                end
                else
                begin
                    rx_bus.valid <= 1'b0;
                end
            end
            res_bus.ready <= ($urandom_range(0, 99) >= take_stall_pct);
        end
    end

    // monitor: checks results, feeds accepted bytes and register writes to the shadow
    always @(posedge clk)
    begin
        rmc_fix_t want;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (fixes_due.size() == 0)
                begin
                    $display("%0t: unexpected fix, expected none, got utc %h", $time,
                             res_bus.utc_time_bcd);
                    mismatches++;
                end
                else
                begin
                    want = fixes_due.pop_front();
                    compare_field("valid_res", want.valid_res, res_bus.valid_res);
                    compare_field("fix_active", want.fix_active, res_bus.fix_active);
                    compare_field("utc_time_bcd", want.utc_time, res_bus.utc_time_bcd);
                    compare_field("local_time_bcd", want.loc_time, res_bus.local_time_bcd);
                    compare_field("date_bcd", want.date, res_bus.date_bcd);
                    compare_field("latitude_bcd", want.lat, res_bus.latitude_bcd);
                    compare_field("north", want.north, res_bus.north);
                    compare_field("longitude_bcd", want.lon, res_bus.longitude_bcd);
                    compare_field("east", want.east, res_bus.east);
                    compare_field("mode_char", want.mode, res_bus.mode_char);
                    fixes_checked++;
                end
            end
            if (rx_bus.valid && rx_bus.ready)
            begin
                predict_byte(rx_bus.rx_byte);
                void'(bytes_to_send.pop_front());
                rx_offered = 1'b0;
                bytes_taken++;
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                m_zone = cfg_bus.zone_offset_hours;
            end
        end
    end

    initial
    begin
        logic [4:0] zone;
        rst_n                     = 1'b0;
        rx_bus.valid              = 1'b0;
        rx_bus.rx_byte            = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.zone_offset_hours = '0;
        res_bus.ready             = 1'b0;
        sent_open      = 1'b0;
        prefix_idx     = 0;
        rmc_ok         = 1'b0;
        field_no       = '0;
        digit_pos      = 0;
        mode_wait      = 0;
        m_time         = '0;
        m_date         = '0;
        m_lat          = '0;
        m_lon          = '0;
        m_north        = 1'b0;
        m_east         = 1'b0;
        m_fix          = 1'b0;
        m_mode         = '0;
        m_zone         = ZONE_RESET;
        send_gap_pct   = 15;
        take_stall_pct = 82;
        rx_offered     = 1'b0;
        fill_count     = 0;
        mismatches     = 0;
        fixes_checked  = 0;
        bytes_taken    = 0;
        zone_writes    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: prefix cut short, wrong talker, bare prefix, bytes outside a
        // sentence, restart on '$', extreme digits, short and long fields, odd status
        push_text("$GN");
        push_byte(CH_CR);
        push_text("$GPRMC,1");
        push_byte(CH_LF);
        push_text("$GNRM");
        push_byte(CH_LF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text("a,9");
        push_byte(CH_CR);
        push_text("$GNRMC,12$GNRMC,235959.99,A,8959.99999,N,17959.999999,E,0.0,0.0,311299");
        push_text(",,,A*7F");
        push_byte(CH_CR);
        push_text("$GNRMC,7a,X,1.,S,12.1234567,W,,,0101,");
        push_byte(CH_LF);
        push_text("$GNRMC,000000,V,,,,,,,010100,,,D");
        push_byte(CH_CR);

        for (int seg = 0; seg < 6; seg++)
        begin
            wait_drained();
            case (seg)
                0:       zone = 5'd23;
                2:       zone = 5'd0;
                3:       zone = 5'd31;
                5:       zone = 5'd13;
                default: zone = 5'($urandom_range(0, 31));
            endcase
            write_zone(zone);
            case (seg / 2)
                0:
                begin
                    send_gap_pct   = 15;
                    take_stall_pct = 82;
                end
                1:
                begin
                    send_gap_pct   = 82;
                    take_stall_pct = 15;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    take_stall_pct = 0;
                end
            endcase
            @(posedge clk);
            fill_count = 0;
            while (fill_count < 230)
            begin
                queue_random_sentence();
            end
        end

        wait_drained();
        $display("%0d bytes parsed, %0d fixes checked, %0d zone offset writes", bytes_taken,
                 fixes_checked, zone_writes);
        if (mismatches == 0 && fixes_due.size() == 0)
        begin
            $display("nmea_rmc_sentence_parser_test OK");
        end
        else
        begin
            $display("nmea_rmc_sentence_parser_test NOT OK");
        end
        $finish;
    end

endmodule
